// ===== rtl/windowed_top_k_signal_ranker_assert.svh =====
// Assertion macros shared by the ranker checker
`ifndef WINDOWED_TOP_K_SIGNAL_RANKER_ASSERT_SVH
`define WINDOWED_TOP_K_SIGNAL_RANKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define WTK_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ranker check failed");

// Next-cycle implication, sampled on clk, off during reset
`define WTK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ranker check failed");

`endif

// ===== rtl/wtk_pkg.sv =====
// Types and constants of the windowed top-k signal ranker
`timescale 1ns / 1ps

package wtk_pkg;

    localparam int TOP_COUNT = 5;
    localparam int IDX_W     = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
    localparam int COUNT_W   = 10;
    localparam int TIME_W    = 32;
    localparam int RSSI_W    = 8;
    localparam int TAG_W     = 8;
    localparam int RANK_W    = 3;
    localparam int MODE_W    = 2;

    localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RECORD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REPORT = 2'd2;

    localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd30000;

    typedef struct packed {
        logic signed [RSSI_W-1:0] rssi;
        logic                     rnd;
        logic [TAG_W-1:0]         tag;
    } entry_t;

    // Insertion chain, handed from cell i to cell i+1
    typedef struct packed {
        logic   take;
        logic   valid;
        entry_t entry;
    } ins_link_t;

    // Report chain, handed from cell i+1 to cell i
    typedef struct packed {
        logic   present;
        entry_t entry;
    } rep_link_t;

    typedef struct packed {
        logic clear;
        logic insert;
        logic snap;
        logic shift;
    } cell_ctl_t;

endpackage

// ===== rtl/wtk_cell.sv =====
// One rank cell: a list entry plus its report shadow
`timescale 1ns / 1ps

module wtk_cell
    import wtk_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  entry_t    new_entry,
    input  ins_link_t ins_prev,
    output ins_link_t ins_out,
    input  rep_link_t rep_next,
    output rep_link_t rep_out
);

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;
    logic   present_reg;
    logic   present_next;
    entry_t rep_entry_reg;
    entry_t rep_entry_next;
    logic   take;

    // Valid entries form a prefix in descending order, so take is monotone
    // along the chain: the first taking cell loads the record, later ones shift.
    assign take = !valid_reg || (new_entry.rssi > entry_reg.rssi);

    assign ins_out.take  = take;
    assign ins_out.valid = valid_reg;
    assign ins_out.entry = entry_reg;

    assign rep_out.present = present_reg;
    assign rep_out.entry   = rep_entry_reg;

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        priority if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.insert && ins_prev.take)
        begin
            valid_next = ins_prev.valid;
            entry_next = ins_prev.entry;
        end
        else if (ctl.insert && take)
        begin
            valid_next = 1'b1;
            entry_next = new_entry;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_comb
    begin
        present_next   = present_reg;
        rep_entry_next = rep_entry_reg;
        priority if (ctl.snap)
        begin
            present_next   = valid_reg;
            rep_entry_next = entry_reg;
        end
        else if (ctl.shift)
        begin
            present_next   = rep_next.present;
            rep_entry_next = rep_next.entry;
        end
        else
        begin
            present_next = present_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            present_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            present_reg <= present_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg     <= entry_next;
        rep_entry_reg <= rep_entry_next;
    end

endmodule

// ===== rtl/wtk_sat_counter.sv =====
// Saturating record counter with synchronous clear
`timescale 1ns / 1ps

module wtk_sat_counter
    import wtk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  logic               inc,
    output logic [COUNT_W-1:0] count
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    always_comb
    begin
        priority if (clear)
        begin
            count_next = '0;
        end
        else if (inc && (count_reg != {COUNT_W{1'b1}}))
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

// ===== rtl/windowed_top_k_signal_ranker.sv =====
// Top level: one request per cycle unless stalled; a record enters the list when taken.
// A report request snapshots the list into the shadow chain; the first result shows the
// next cycle and one result per cycle follows (1..TOP_COUNT results) while out_ready holds.
// Records and pass starts keep flowing during a report; a second report request waits
// only until the last result of the one in flight is taken.
// Reset clears the list, the counters and pass time; the window register resets to 30000.
`timescale 1ns / 1ps

module windowed_top_k_signal_ranker
    import wtk_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [TIME_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [MODE_W-1:0]        mode,
    input  logic [TIME_W-1:0]        now_time,
    input  logic [TIME_W-1:0]        last_seen,
    input  logic signed [RSSI_W-1:0] rssi,
    input  logic                     is_random,
    input  logic                     has_name,
    input  logic [TAG_W-1:0]         device_tag,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     entry_valid,
    output logic [RANK_W-1:0]        rank,
    output logic signed [RSSI_W-1:0] out_rssi,
    output logic                     out_random,
    output logic [TAG_W-1:0]         out_tag,
    output logic [COUNT_W-1:0]       total_count,
    output logic [COUNT_W-1:0]       random_count,
    output logic [COUNT_W-1:0]       named_count,
    output logic                     last
);

    logic [TIME_W-1:0]  window_reg;
    logic [TIME_W-1:0]  pass_time_reg;
    logic [TIME_W-1:0]  age;
    logic               in_window;
    logic               in_fire;
    logic               out_fire;
    logic               busy;
    logic               finishing;
    cell_ctl_t          ctl;
    entry_t             new_entry;
    ins_link_t          ins_in  [TOP_COUNT];
    ins_link_t          ins_out [TOP_COUNT];
    rep_link_t          rep_link [TOP_COUNT+1];
    logic [COUNT_W-1:0] total_seen;
    logic [COUNT_W-1:0] random_seen;
    logic [COUNT_W-1:0] named_seen;
    logic [COUNT_W-1:0] snap_total_reg;
    logic [COUNT_W-1:0] snap_random_reg;
    logic [COUNT_W-1:0] snap_named_reg;
    logic               empty_reg;
    logic               empty_next;
    logic [IDX_W-1:0]   rank_reg;
    logic [IDX_W-1:0]   rank_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WINDOW_RESET;
            pass_time_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                window_reg <= cfg_data;
            end
            if (ctl.clear)
            begin
                pass_time_reg <= now_time;
            end
        end
    end

    assign busy      = rep_link[0].present || empty_reg;
    assign out_valid = busy;
    assign out_fire  = out_valid && out_ready;
    assign finishing = out_fire && last;

    // A report waits for the previous one to drain; other requests never stall.
    assign in_ready = !((mode == MODE_REPORT) && busy && !finishing);
    assign in_fire  = in_valid && in_ready;

    assign age       = pass_time_reg - last_seen;
    assign in_window = (age <= window_reg);

    assign ctl.clear  = in_fire && (mode == MODE_START);
    assign ctl.insert = in_fire && (mode == MODE_RECORD) && in_window;
    assign ctl.snap   = in_fire && (mode == MODE_REPORT);
    assign ctl.shift  = out_fire;

    assign new_entry.rssi = rssi;
    assign new_entry.rnd  = is_random;
    assign new_entry.tag  = device_tag;

    assign ins_in[0]          = '0;
    assign rep_link[TOP_COUNT] = '0;

    for (genvar i = 0; i < TOP_COUNT; i++)
    begin : g_cell
        if (i > 0)
        begin : g_link
            assign ins_in[i] = ins_out[i-1];
        end
        wtk_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .new_entry (new_entry),
            .ins_prev  (ins_in[i]),
            .ins_out   (ins_out[i]),
            .rep_next  (rep_link[i+1]),
            .rep_out   (rep_link[i])
        );
    end

    wtk_sat_counter u_total (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (ctl.clear),
        .inc   (ctl.insert),
        .count (total_seen)
    );

    wtk_sat_counter u_random (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (ctl.clear),
        .inc   (ctl.insert && is_random),
        .count (random_seen)
    );

    wtk_sat_counter u_named (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (ctl.clear),
        .inc   (ctl.insert && has_name),
        .count (named_seen)
    );

    always_comb
    begin
        priority if (ctl.snap)
        begin
            empty_next = !ins_out[0].valid;
            rank_next  = '0;
        end
        else if (ctl.shift)
        begin
            empty_next = 1'b0;
            rank_next  = rank_reg + IDX_W'(1);
        end
        else
        begin
            empty_next = empty_reg;
            rank_next  = rank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            empty_reg <= empty_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.snap)
        begin
            snap_total_reg  <= total_seen;
            snap_random_reg <= random_seen;
            snap_named_reg  <= named_seen;
        end
    end

    assign entry_valid  = !empty_reg;
    assign rank         = empty_reg ? '0 : RANK_W'(rank_reg);
    assign out_rssi     = empty_reg ? '0 : rep_link[0].entry.rssi;
    assign out_random   = empty_reg ? 1'b0 : rep_link[0].entry.rnd;
    assign out_tag      = empty_reg ? '0 : rep_link[0].entry.tag;
    assign total_count  = snap_total_reg;
    assign random_count = snap_random_reg;
    assign named_count  = snap_named_reg;
    assign last         = empty_reg || !rep_link[1].present;

endmodule

// ===== rtl/wtk_checker.sv =====
// Port-level checker for the ranker, bound to the top level
`timescale 1ns / 1ps
`include "windowed_top_k_signal_ranker_assert.svh"

module wtk_checker
    import wtk_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic                     entry_valid,
    input logic [RANK_W-1:0]        rank,
    input logic signed [RSSI_W-1:0] out_rssi,
    input logic [TAG_W-1:0]         out_tag,
    input logic                     last
);

    // stalled result holds
    `WTK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(rank) && $stable(out_tag) && $stable(last))

    // empty report is a single result at rank 0
    `WTK_ASSERT_NOW(a_empty_single, out_valid && !entry_valid, last && (rank == '0))

    // ranks of one report count up without gaps
    `WTK_ASSERT_NEXT(a_rank_step, out_valid && out_ready && !last, out_valid && entry_valid && (rank == RANK_W'($past(rank) + RANK_W'(1))))

    // list comes out strongest first
    `WTK_ASSERT_NEXT(a_descending, out_valid && out_ready && !last, $signed(out_rssi) <= $signed($past(out_rssi)))

endmodule

bind windowed_top_k_signal_ranker wtk_checker u_wtk_checker (.*);
